// ----- hw/rtl/bev_pkg.sv -----
package bev_pkg;

	// Mapped entries and fixed field widths
	localparam int unsigned MAP_ENTRIES = 14;
	localparam int unsigned ENTRY_W     = 4;
	localparam int unsigned AXIS_W      = 16;
	localparam int unsigned THR_W       = 15;

	// Direction entries that the stick folds into
	localparam logic [ENTRY_W-1:0] DIR_UP    = 4'd0;
	localparam logic [ENTRY_W-1:0] DIR_DOWN  = 4'd1;
	localparam logic [ENTRY_W-1:0] DIR_LEFT  = 4'd2;
	localparam logic [ENTRY_W-1:0] DIR_RIGHT = 4'd3;

	// Configuration register indexes
	localparam logic CFG_THRESHOLD = 1'b0;
	localparam logic CFG_ENABLED   = 1'b1;

	localparam logic [THR_W-1:0] THRESHOLD_RESET = 15'd16000;

	// Stream payload widths
	localparam int unsigned IN_DATA_W  = 48;
	localparam int unsigned OUT_DATA_W = 8;

	// One queued event: entry index above, press flag in bit 0
	typedef struct packed {
		logic [ENTRY_W-1:0] entry;
		logic               down;
	} event_t;

endpackage

// ----- hw/rtl/bev_fold.sv -----
module bev_fold
	import bev_pkg::*;
(
	input  logic [MAP_ENTRIES-1:0] buttons,
	input  logic [AXIS_W-1:0]      stick_x,
	input  logic [AXIS_W-1:0]      stick_y,
	input  logic [THR_W-1:0]       threshold,
	output logic [MAP_ENTRIES-1:0] folded
);

	logic signed [AXIS_W:0] sx;
	logic signed [AXIS_W:0] sy;
	logic signed [AXIS_W:0] thr_pos;
	logic signed [AXIS_W:0] thr_neg;

	// Widen axes and threshold to a common signed width
	assign sx      = $signed({stick_x[AXIS_W-1], stick_x});
	assign sy      = $signed({stick_y[AXIS_W-1], stick_y});
	assign thr_pos = $signed({2'b00, threshold});
	assign thr_neg = -thr_pos;

	// Fold the stick onto the direction entries
	always_comb begin
		folded = buttons;
		if (sy > thr_pos) folded[DIR_UP]    = 1'b1;
		if (sy < thr_neg) folded[DIR_DOWN]  = 1'b1;
		if (sx < thr_neg) folded[DIR_LEFT]  = 1'b1;
		if (sx > thr_pos) folded[DIR_RIGHT] = 1'b1;
	end

endmodule

// ----- hw/rtl/button_edge_event_queue.sv -----
// Button edge event queue: one result per poll, one poll at a time.
// After an enabled input transfer the edges are captured; the edge scan then visits 2 x 14
// candidates, press then release per entry, writing an event slot of the ring memory for
// each edge while the ring has room; then at most one ring read and the output load. A disabled
// poll goes straight to the output load. The next poll is taken the cycle after that load.
// Reset (arst_n low) clears pointers and previous sample and reloads the register defaults;
// ring contents are left undefined and are only read after being written.
module button_edge_event_queue
	import bev_pkg::*;
#(
	parameter int unsigned QUEUE_SLOTS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Poll input: buttons[13:0], stick_x[29:14], stick_y[45:30], zero pad
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// Result: event_valid[0], entry_index[4:1], key_down[5], zero pad
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	// Configuration write
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [THR_W-1:0]      cfg_data
);

	localparam int unsigned PTR_W = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_SLOTS - 1);
	localparam logic [ENTRY_W-1:0] ENTRY_LAST = ENTRY_W'(MAP_ENTRIES - 1);
	localparam int unsigned EV_W = $bits(event_t);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_POP  = 3'd2;
	localparam logic [2:0] ST_DONE = 3'd3;

	logic [2:0]             state_q;
	logic [THR_W-1:0]       threshold_q;
	logic                   enabled_q;
	logic [MAP_ENTRIES-1:0] prev_q;
	logic [MAP_ENTRIES-1:0] pressed_q;
	logic [MAP_ENTRIES-1:0] released_q;
	logic [ENTRY_W-1:0]     idx_q;
	logic                   phase_q;
	logic [PTR_W-1:0]       rd_ptr_q;
	logic [PTR_W-1:0]       wr_ptr_q;
	logic                   pop_q;
	logic                   out_valid_q;
	event_t                 out_ev_q;
	logic                   out_pop_q;

	logic [MAP_ENTRIES-1:0] folded;
	logic [PTR_W-1:0]       wr_next;
	logic [PTR_W-1:0]       rd_next;
	logic                   in_xfer;
	logic                   cand;
	logic                   wr_en;
	logic                   rd_en;
	logic                   load_out;
	event_t                 wr_ev;
	event_t                 rd_data_s1;

	logic [EV_W-1:0]        ring_mem [QUEUE_SLOTS];

	bev_fold u_fold (
		.buttons  (s_tdata[MAP_ENTRIES-1:0]),
		.stick_x  (s_tdata[MAP_ENTRIES +: AXIS_W]),
		.stick_y  (s_tdata[MAP_ENTRIES+AXIS_W +: AXIS_W]),
		.threshold(threshold_q),
		.folded   (folded)
	);

	// Handshake decode
	assign s_tready  = (state_q == ST_IDLE);
	assign in_xfer   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign load_out  = (state_q == ST_DONE) && (!out_valid_q || m_tready);

	// Ring pointer advance with wrap
	assign wr_next = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
	assign rd_next = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;

	// Current scan candidate: press phase first, then release
	assign cand        = phase_q ? released_q[idx_q] : pressed_q[idx_q];
	assign wr_en       = (state_q == ST_SCAN) && cand && (wr_next != rd_ptr_q);
	assign wr_ev.entry = idx_q;
	assign wr_ev.down  = ~phase_q;
	assign rd_en       = (state_q == ST_POP) && (rd_ptr_q != wr_ptr_q);

	// Event ring memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) ring_mem[wr_ptr_q] <= wr_ev;
		if (rd_en) rd_data_s1 <= ring_mem[rd_ptr_q];
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
			enabled_q   <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_THRESHOLD: threshold_q <= cfg_data;
				CFG_ENABLED:   enabled_q   <= cfg_data[0];
				default:       ;
			endcase
		end
	end

	// Poll sequencer: fold, scan edges into the ring, pop at most one; skipped when disabled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			prev_q     <= '0;
			pressed_q  <= '0;
			released_q <= '0;
			idx_q      <= '0;
			phase_q    <= 1'b0;
			rd_ptr_q   <= '0;
			wr_ptr_q   <= '0;
			pop_q      <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						idx_q   <= '0;
						phase_q <= 1'b0;
						pop_q   <= 1'b0;
						if (enabled_q) begin
							pressed_q  <= folded & ~prev_q;
							released_q <= ~folded & prev_q;
							prev_q     <= folded;
							state_q    <= ST_SCAN;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					if (wr_en) wr_ptr_q <= wr_next;
					phase_q <= ~phase_q;
					if (phase_q) begin
						idx_q <= idx_q + 1'b1;
						if (idx_q == ENTRY_LAST) state_q <= ST_POP;
					end
				end
				ST_POP: begin
					pop_q <= rd_en;
					if (rd_en) rd_ptr_q <= rd_next;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load_out) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register: hold the result until transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_pop_q <= pop_q;
			out_ev_q  <= pop_q ? rd_data_s1 : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_ev_q.down, out_ev_q.entry, out_pop_q};

endmodule

// ----- test/button_edge_event_queue_tb.sv -----
`timescale 1ns / 100ps

module button_edge_event_queue_tb;
	import bev_pkg::*;

	localparam int unsigned RING_SLOTS  = 32;
	localparam int unsigned PTR_W       = $clog2(RING_SLOTS);
	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned PHASE_POLLS = 200;

	// Expected outcome of one poll
	typedef struct packed {
		logic               has_event;
		logic [ENTRY_W-1:0] entry;
		logic               down;
	} poll_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// buttons[13:0], stick_x[29:14], stick_y[45:30], zero pad
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// event_valid[0], entry_index[4:1], key_down[5], zero pad
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic                  cfg_index = CFG_THRESHOLD;
	logic [THR_W-1:0]      cfg_data = '0;

	// Shadow of the block: registers, previous sample and event ring
	logic [THR_W-1:0]       shadow_threshold;
	logic                   shadow_enabled;
	logic [MAP_ENTRIES-1:0] shadow_prev;
	event_t                 shadow_ring [RING_SLOTS];
	logic [PTR_W-1:0]       shadow_rd;
	logic [PTR_W-1:0]       shadow_wr;

	poll_result_t expected_events [$];

	// Stimulus bookkeeping
	logic                   tx_steady = 1'b0;
	logic                   rx_steady = 1'b0;
	logic [MAP_ENTRIES-1:0] last_buttons = '0;
	logic [AXIS_W-1:0]      last_x = '0;
	logic [AXIS_W-1:0]      last_y = '0;
	int                     errors = 0;
	int                     polls_sent = 0;
	int                     events_seen = 0;
	int                     events_dropped = 0;
	int                     settings_used = 0;
	int                     quiet_cycles = 0;

	button_edge_event_queue DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #1 clk = ~clk;

	// Queue one edge event; drop it when the ring is full
	function automatic void push_edge(input logic [ENTRY_W-1:0] entry, input logic down);
		logic [PTR_W-1:0] next;
		next = shadow_wr + 1'b1;
		if (next == shadow_rd) begin
			events_dropped++;
		end else begin
			shadow_ring[shadow_wr] = '{entry: entry, down: down};
			shadow_wr = next;
		end
	endfunction

	// Fold the stick, queue the edges, pop at most one event
	function automatic poll_result_t poll_outcome(input logic [MAP_ENTRIES-1:0] btn,
			input logic [AXIS_W-1:0] sx, input logic [AXIS_W-1:0] sy);
		logic [MAP_ENTRIES-1:0] cur;
		logic [MAP_ENTRIES-1:0] pressed;
		logic [MAP_ENTRIES-1:0] released;
		int                     thr;
		int                     x;
		int                     y;
		poll_result_t           res;
		res = '0;
		if (!shadow_enabled)
			return res;
		thr = int'(shadow_threshold);
		x = int'($signed(sx));
		y = int'($signed(sy));
		cur = btn;
		if (y > thr)
			cur[DIR_UP] = 1'b1;
		if (y < -thr)
			cur[DIR_DOWN] = 1'b1;
		if (x < -thr)
			cur[DIR_LEFT] = 1'b1;
		if (x > thr)
			cur[DIR_RIGHT] = 1'b1;
		pressed = cur & ~shadow_prev;
		released = ~cur & shadow_prev;
		for (int i = 0; i < MAP_ENTRIES; i++) begin
			if (pressed[i])
				push_edge(ENTRY_W'(i), 1'b1);
			if (released[i])
				push_edge(ENTRY_W'(i), 1'b0);
		end
		shadow_prev = cur;
		if (shadow_rd != shadow_wr) begin
			res.has_event = 1'b1;
			res.entry = shadow_ring[shadow_rd].entry;
			res.down = shadow_ring[shadow_rd].down;
			shadow_rd = shadow_rd + 1'b1;
		end
		return res;
	endfunction

	// Send one poll after a random gap and record its outcome on transfer
	task automatic send_poll(input logic [MAP_ENTRIES-1:0] btn, input logic [AXIS_W-1:0] sx,
			input logic [AXIS_W-1:0] sy);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 11);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata <= {2'b00, sy, sx, btn};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		expected_events.push_back(poll_outcome(btn, sx, sy));
		polls_sent++;
		last_buttons = btn;
		last_x = sx;
		last_y = sy;
	endtask

	// Drop valid and wait until every result has come back
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_events.size() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [THR_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_THRESHOLD)
			shadow_threshold = value;
		else
			shadow_enabled = value[0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(input logic [THR_W-1:0] thr, input logic en);
		settle();
		write_reg(CFG_THRESHOLD, thr);
		write_reg(CFG_ENABLED, THR_W'(en));
		settings_used++;
	endtask

	// Axis value biased toward the threshold edges and the extremes
	function automatic logic [AXIS_W-1:0] pick_axis();
		int v;
		case ($urandom_range(0, 7))
			0: v = 0;
			1: v = 32767;
			2: v = -32768;
			3: v = int'(shadow_threshold) - 1 + int'($urandom_range(0, 2));
			4: v = -int'(shadow_threshold) - 1 + int'($urandom_range(0, 2));
			default: v = int'($urandom_range(0, 65535)) - 32768;
		endcase
		if (v > 32767)
			v = 32767;
		return v[AXIS_W-1:0];
	endfunction

	// Empty ring at reset: a quiet poll reports nothing
	task automatic test_startup_state();
		send_poll('0, '0, '0);
	endtask

	// Stick folding around the reset threshold and at the axis extremes
	task automatic test_stick_fold();
		send_poll('0, 16'sd0, 16'sd16000);
		send_poll('0, 16'sd0, 16'sd16001);
		send_poll('0, 16'sd0, -16'sd16001);
		send_poll('0, -16'sd16001, -16'sd16000);
		send_poll('0, 16'sd16001, 16'sd0);
		send_poll('0, 16'sh7FFF, 16'sh8000);
		send_poll('0, 16'sh8000, 16'sh7FFF);
	endtask

	// All entries toggling at once overruns the ring
	task automatic test_ring_overflow();
		send_poll('1, 16'sh7FFF, 16'sh7FFF);
		send_poll('0, 16'sd0, 16'sd0);
		send_poll('1, 16'sd0, 16'sd0);
		send_poll('0, 16'sd0, 16'sd0);
		send_poll('1, 16'sd0, 16'sd0);
		send_poll(14'h2AAA, 16'sd0, 16'sd0);
		send_poll(14'h1555, 16'sd0, 16'sd0);
	endtask

	// Threshold zero: any nonzero axis is a direction
	task automatic test_zero_threshold();
		configure('0, 1'b1);
		send_poll('0, 16'sd1, 16'sd0);
		send_poll('0, -16'sd1, 16'sd0);
		send_poll('0, 16'sd0, 16'sd1);
		send_poll('0, 16'sd0, -16'sd1);
	endtask

	// Maximum threshold: only the most negative value gets past it
	task automatic test_max_threshold();
		configure('1, 1'b1);
		send_poll('0, 16'sh7FFF, 16'sh7FFF);
		send_poll('0, 16'sh8000, 16'sh8000);
		send_poll('0, 16'sd0, 16'sd0);
	endtask

	// Disabled polls leave all state alone and report nothing
	task automatic test_disabled();
		configure(THRESHOLD_RESET, 1'b0);
		send_poll('1, 16'sh7FFF, 16'sh8000);
		send_poll('0, 16'sd0, 16'sd0);
		configure(THRESHOLD_RESET, 1'b1);
		send_poll(last_buttons, last_x, last_y);
	endtask

	// Random polls: small edge changes, holds to drain and bursts to fill
	task automatic run_random_phase(input logic [THR_W-1:0] thr, input logic en, input int count);
		logic [MAP_ENTRIES-1:0] btn;
		logic [AXIS_W-1:0]      sx;
		logic [AXIS_W-1:0]      sy;
		configure(thr, en);
		for (int n = 0; n < count; n++) begin
			if (n % 50 == 0) begin
				tx_steady = ($urandom_range(0, 3) == 0);
				rx_steady = ($urandom_range(0, 3) == 0);
			end
			btn = last_buttons;
			sx = last_x;
			sy = last_y;
			case ($urandom_range(0, 7))
				0, 1, 2: begin
					btn[$urandom_range(0, MAP_ENTRIES - 1)] ^= 1'b1;
					if ($urandom_range(0, 1))
						btn[$urandom_range(0, MAP_ENTRIES - 1)] ^= 1'b1;
				end
				3, 4, 5: ;
				6: btn = MAP_ENTRIES'($urandom_range(0, 16383));
				default: btn = ~last_buttons;
			endcase
			case ($urandom_range(0, 3))
				0, 1: ;
				2: begin
					sx = '0;
					sy = '0;
				end
				default: begin
					sx = pick_axis();
					sy = pick_axis();
				end
			endcase
			send_poll(btn, sx, sy);
		end
	endtask

	task automatic test_random();
		run_random_phase(THRESHOLD_RESET, 1'b1, PHASE_POLLS);
		run_random_phase('0, 1'b1, PHASE_POLLS);
		run_random_phase('1, 1'b1, PHASE_POLLS);
		run_random_phase(THR_W'(1), 1'b1, PHASE_POLLS);
		run_random_phase(THR_W'($urandom_range(0, 32767)), 1'b0, 30);
		run_random_phase(THR_W'($urandom_range(0, 32767)), 1'b1, PHASE_POLLS);
		run_random_phase(THR_W'($urandom_range(0, 32767)), 1'b1, PHASE_POLLS);
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	// Hold ready low for a random stall per result
	always begin
		int stall;
		stall = rx_steady ? 0 : $urandom_range(0, 11);
		@(negedge clk);
		if (stall > 0) begin
			m_tready <= 1'b0;
			repeat (stall) @(negedge clk);
		end
		m_tready <= 1'b1;
		do @(posedge clk); while (!m_tvalid);
	end

	// Compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		poll_result_t head;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_events.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual tdata %h", $time, m_tdata);
			end else begin
				head = expected_events.pop_front();
				if (m_tdata[0])
					events_seen++;
				if (m_tdata[0] !== head.has_event) begin
					errors++;
					$display("%0t: event_valid expected %0d actual %0d", $time,
						head.has_event, m_tdata[0]);
				end
				if (m_tdata[4:1] !== head.entry) begin
					errors++;
					$display("%0t: entry_index expected %0d actual %0d", $time,
						head.entry, m_tdata[4:1]);
				end
				if (m_tdata[5] !== head.down) begin
					errors++;
					$display("%0t: key_down expected %0d actual %0d", $time,
						head.down, m_tdata[5]);
				end
			end
		end
	end

	// Abort when no transfer happens for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: timeout, %0d results outstanding", $time, expected_events.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		shadow_threshold = THRESHOLD_RESET;
		shadow_enabled = 1'b1;
		shadow_prev = '0;
		shadow_rd = '0;
		shadow_wr = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		test_startup_state();
		test_stick_fold();
		test_ring_overflow();
		test_zero_threshold();
		test_max_threshold();
		test_disabled();
		test_random();

		settle();
		repeat (40) @(posedge clk);
		$display("Covered %0d polls over %0d register settings: %0d events seen, %0d dropped",
			polls_sent, settings_used, events_seen, events_dropped);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches", errors);
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/bev_pkg.sv
hw/rtl/bev_fold.sv
hw/rtl/button_edge_event_queue.sv
test/button_edge_event_queue_tb.sv
